// ----- design/assert_macros.svh -----
// assertion helpers included by the line buffer rtl
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/lerb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lerb_pkg
// types and constants of the cooked-mode receive line buffer
// ----------------------------------------------------------------------------
package lerb_pkg;

    // ring depth and derived widths
    localparam int RX_DEPTH = 256;
    localparam int PTR_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CNT_W    = $clog2(RX_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RX_DEPTH - 1);
    localparam logic [CNT_W:0]   FILL_FULL = (CNT_W + 1)'(RX_DEPTH);

    // operations
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    // characters
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_SP  = 8'h20;

    // result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ECHO_SP,
        ST_ECHO_BS
    } state_t;

endpackage : lerb_pkg
`default_nettype wire

// ----- design/line_edit_receive_buffer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_edit_receive_buffer_unit
// cooked-mode console receive buffer with line editing and echo
// ----------------------------------------------------------------------------
// usage
//   command channel: a beat is taken at a clock edge with start high and
//   busy low. operation 0 hands over a byte from the line in rx_byte,
//   operation 1 asks for one released byte.
//   result channel: each result beat is on the result ports for exactly one
//   cycle with result_valid high; last marks the final beat of a command.
// result timing
//   ordinary byte, carriage return, overflow, empty read: one result in the
//   cycle after the command, busy stays low, one command per cycle.
//   read with data: the ring memory has a registered read, so the data passes
//   through rd_data_reg and then the result registers; busy is high for one cycle.
//   DEL: three echo beats (backspace, space, backspace) back to back, with busy
//   high in ST_ECHO_SP and ST_ECHO_BS, so the next command waits for the last beat.
//   a DEL on an empty open line gives no result at all.
// reset
//   pointers and counts clear, the ring contents stay undefined; the block
//   takes commands in the first cycle after reset.
// the receiver cannot stall: results are never held back.
// ----------------------------------------------------------------------------
module line_edit_receive_buffer_unit
    import lerb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       operation,
    input  wire logic [7:0] rx_byte,
    output logic            result_valid,
    output logic [1:0]      result_kind,
    output logic [7:0]      data,
    output logic            end_of_line,
    output logic            overflow,
    output logic            last
);

    `include "assert_macros.svh"

    // ring memory, synchronous registered read
    logic [7:0] ring_mem [RX_DEPTH];
    logic [7:0] rd_data_reg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;

    state_t state_reg, state_next;

    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0] released_reg, released_next;
    logic [CNT_W-1:0] open_reg, open_next;

    // registered result beat
    logic       res_valid_reg, res_valid_next;
    logic [1:0] res_kind_reg, res_kind_next;
    logic [7:0] res_data_reg, res_data_next;
    logic       res_eol_reg, res_eol_next;
    logic       res_ovf_reg, res_ovf_next;
    logic       res_last_reg, res_last_next;

    logic             accept;
    logic [CNT_W:0]   fill_sum;
    logic             ring_full;
    logic [PTR_W-1:0] wptr_inc;
    logic [PTR_W-1:0] wptr_dec;
    logic [PTR_W-1:0] rptr_inc;
    logic             res_is_data;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // occupancy of the ring: released bytes plus the line being edited
    assign fill_sum  = {1'b0, released_reg} + {1'b0, open_reg};
    assign ring_full = (fill_sum >= FILL_FULL);

    // ring pointer stepping, wraps at any depth
    assign wptr_inc = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
    assign wptr_dec = (wptr_reg == '0) ? PTR_LAST : wptr_reg - PTR_W'(1);
    assign rptr_inc = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_READ)
                    begin
                        if (released_reg != '0)
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else if (rx_byte == CH_DEL && open_reg != '0)
                    begin
                        state_next = ST_ECHO_SP;
                    end
                end
            end
            ST_READ:    state_next = ST_IDLE;
            ST_ECHO_SP: state_next = ST_ECHO_BS;
            ST_ECHO_BS: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath, memory write and result beat
    always_comb
    begin
        rptr_next     = rptr_reg;
        wptr_next     = wptr_reg;
        released_next = released_reg;
        open_next     = open_reg;

        mem_we    = 1'b0;
        mem_waddr = wptr_reg;
        mem_wdata = rx_byte;

        res_valid_next = 1'b0;
        res_kind_next  = KIND_ECHO;
        res_data_next  = res_data_reg;
        res_eol_next   = 1'b0;
        res_ovf_next   = 1'b0;
        res_last_next  = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_READ)
                    begin
                        if (released_reg == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_kind_next  = KIND_EMPTY;
                            res_data_next  = 8'h00;
                        end
                        else
                        begin
                            // data shows up in rd_data_reg next cycle
                            rptr_next     = rptr_inc;
                            released_next = released_reg - CNT_W'(1);
                        end
                    end
                    else if (rx_byte == CH_DEL)
                    begin
                        if (open_reg != '0)
                        begin
                            wptr_next      = wptr_dec;
                            open_next      = open_reg - CNT_W'(1);
                            res_valid_next = 1'b1;
                            res_data_next  = CH_BS;
                            res_last_next  = 1'b0;
                        end
                    end
                    else if (ring_full)
                    begin
                        // byte dropped, no echo
                        res_valid_next = 1'b1;
                        res_data_next  = 8'h00;
                        res_ovf_next   = 1'b1;
                    end
                    else if (rx_byte == CH_CR)
                    begin
                        // store newline and release the whole open line
                        mem_we         = 1'b1;
                        mem_wdata      = CH_LF;
                        wptr_next      = wptr_inc;
                        released_next  = CNT_W'(fill_sum + (CNT_W + 1)'(1));
                        open_next      = '0;
                        res_valid_next = 1'b1;
                        res_data_next  = CH_LF;
                    end
                    else
                    begin
                        mem_we         = 1'b1;
                        wptr_next      = wptr_inc;
                        open_next      = open_reg + CNT_W'(1);
                        res_valid_next = 1'b1;
                        res_data_next  = rx_byte;
                    end
                end
            end
            ST_READ:
            begin
                res_valid_next = 1'b1;
                res_kind_next  = KIND_DATA;
                res_data_next  = rd_data_reg;
                res_eol_next   = (rd_data_reg == CH_LF);
            end
            ST_ECHO_SP:
            begin
                res_valid_next = 1'b1;
                res_data_next  = CH_SP;
                res_last_next  = 1'b0;
            end
            ST_ECHO_BS:
            begin
                res_valid_next = 1'b1;
                res_data_next  = CH_BS;
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    // ring memory: one write port, one registered read port at the read pointer;
    // a read is issued only after the write of an earlier command has landed
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[rptr_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            released_reg  <= '0;
            open_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rptr_reg      <= rptr_next;
            wptr_reg      <= wptr_next;
            released_reg  <= released_next;
            open_reg      <= open_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_kind_reg <= res_kind_next;
        res_data_reg <= res_data_next;
        res_eol_reg  <= res_eol_next;
        res_ovf_reg  <= res_ovf_next;
        res_last_reg <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign data         = res_data_reg;
    assign end_of_line  = res_eol_reg;
    assign overflow     = res_ovf_reg;
    assign last         = res_last_reg;

    // checks
    assign res_is_data = result_valid && (result_kind == KIND_DATA);

    // the ring never holds more than its depth
    `ASSERT_NEVER(a_fill_bound, fill_sum > FILL_FULL, "ring occupancy above depth")

    // a beat that is not last is always followed by another beat
    `ASSERT_CLK(a_burst_cont, (result_valid && !last) |=> result_valid, "echo burst broken")

    // read data comes only out of the memory wait cycle
    `ASSERT_CLK(a_read_src, res_is_data |-> $past(state_reg == ST_READ), "stray read data")

endmodule : line_edit_receive_buffer_unit
`default_nettype wire

// ----- tb/sv/line_edit_receive_buffer_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_receive_buffer_unit_test
// self-checking bench for the cooked-mode receive line buffer: commands are
// driven with random sender gaps, a shadow copy of the ring predicts every
// echo and read beat, and each result beat is checked field by field
// ----------------------------------------------------------------------------
module line_edit_receive_buffer_unit_test;
    import lerb_pkg::*;

    // one result beat as seen on the result ports
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       eol;
        logic       ovf;
        logic       last_beat;
    } line_beat_t;

    // shadow of the ring plus the queue of beats still owed by the block
    class line_buffer_scoreboard;
        logic [7:0]       line_copy [RX_DEPTH];
        logic [PTR_W-1:0] rd_ptr;
        logic [PTR_W-1:0] wr_ptr;
        logic [CNT_W-1:0] released;
        logic [CNT_W-1:0] open_len;
        line_beat_t       owed_beats [$];
        int               errors;

        function new();
            rd_ptr   = '0;
            wr_ptr   = '0;
            released = '0;
            open_len = '0;
            errors   = 0;
        endfunction

        function logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
            return (p == PTR_LAST) ? '0 : p + 1'b1;
        endfunction

        function void owe_beat(logic [1:0] kind, logic [7:0] data, logic eol,
                               logic ovf, logic last_beat);
            line_beat_t b;
            b.kind      = kind;
            b.data      = data;
            b.eol       = eol;
            b.ovf       = ovf;
            b.last_beat = last_beat;
            owed_beats.push_back(b);
        endfunction

        function int occupancy();
            return int'(released) + int'(open_len);
        endfunction

        function int readable();
            return int'(released);
        endfunction

        // called for every command beat the block takes
        function void note_command(logic op, logic [7:0] rx);
            logic [7:0] v;
            if (op == OP_READ) begin
                if (released == 0) begin
                    owe_beat(KIND_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1);
                end else begin
                    v        = line_copy[rd_ptr];
                    rd_ptr   = ptr_next(rd_ptr);
                    released = released - 1'b1;
                    owe_beat(KIND_DATA, v, v == CH_LF, 1'b0, 1'b1);
                end
            end else if (rx == CH_DEL) begin
                if (open_len != 0) begin
                    wr_ptr   = (wr_ptr == '0) ? PTR_LAST : wr_ptr - 1'b1;
                    open_len = open_len - 1'b1;
                    owe_beat(KIND_ECHO, CH_BS, 1'b0, 1'b0, 1'b0);
                    owe_beat(KIND_ECHO, CH_SP, 1'b0, 1'b0, 1'b0);
                    owe_beat(KIND_ECHO, CH_BS, 1'b0, 1'b0, 1'b1);
                end
            end else if (occupancy() >= RX_DEPTH) begin
                owe_beat(KIND_ECHO, 8'h00, 1'b0, 1'b1, 1'b1);
            end else if (rx == CH_CR) begin
                line_copy[wr_ptr] = CH_LF;
                wr_ptr            = ptr_next(wr_ptr);
                released          = released + open_len + 1'b1;
                open_len          = '0;
                owe_beat(KIND_ECHO, CH_LF, 1'b0, 1'b0, 1'b1);
            end else begin
                line_copy[wr_ptr] = rx;
                wr_ptr            = ptr_next(wr_ptr);
                open_len          = open_len + 1'b1;
                owe_beat(KIND_ECHO, rx, 1'b0, 1'b0, 1'b1);
            end
        endfunction

        // called for every result beat
        function void check_result(line_beat_t got);
            line_beat_t want;
            if (owed_beats.size() == 0) begin
                $error("result beat with none owed: kind %0d data %02h",
                       got.kind, got.data);
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            if (got.kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.data !== want.data) begin
                $error("data: expected %02h, actual %02h", want.data, got.data);
                errors++;
            end
            if (got.eol !== want.eol) begin
                $error("end_of_line: expected %0b, actual %0b", want.eol, got.eol);
                errors++;
            end
            if (got.ovf !== want.ovf) begin
                $error("overflow: expected %0b, actual %0b", want.ovf, got.ovf);
                errors++;
            end
            if (got.last_beat !== want.last_beat) begin
                $error("last: expected %0b, actual %0b", want.last_beat, got.last_beat);
                errors++;
            end
        endfunction
    endclass

    // quiet cycles allowed before the run is declared hung
    localparam int QUIET_LIMIT = 4000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       operation = OP_RX;
    logic [7:0] rx_byte   = 8'h00;
    logic       busy;
    logic       result_valid;
    logic [1:0] result_kind;
    logic [7:0] data;
    logic       end_of_line;
    logic       overflow;
    logic       last;

    line_buffer_scoreboard board = new();

    // percent of chances the sender spends idle before a command
    int sender_idle_pct = 0;
    int quiet_cycles    = 0;

    line_edit_receive_buffer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .data         (data),
        .end_of_line  (end_of_line),
        .overflow     (overflow),
        .last         (last)
    );

    always #5 clk = ~clk;

    // monitor: all values here are the ones settled before the edge
    always @(posedge clk) begin
        if (rst_n) begin
            // a command beat is taken when start is high and busy is low
            if (start && !busy) begin
                board.note_command(operation, rx_byte);
            end
            // result beats cannot be held off, so each one is checked at once
            if (result_valid) begin
                board.check_result({result_kind, data, end_of_line, overflow, last});
            end
        end
    end

    // watchdog: any beat on either side counts as progress
    always @(posedge clk) begin
        if (rst_n && ((start && !busy) || result_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[line_edit_receive_buffer_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // optional sender gap, then one command held until the block takes it;
    // returns on the edge that took the beat, with start still high
    task automatic send_command(input logic op, input logic [7:0] rx);
        while ($urandom_range(99) < sender_idle_pct) begin
            start     <= 1'b0;
            // junk on the payload while start is low must be ignored
            operation <= 1'($urandom_range(1));
            rx_byte   <= 8'($urandom_range(255));
            @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        rx_byte   <= rx;
        do @(posedge clk); while (busy);
    endtask

    initial begin
        int          idle_plan [4];
        int          pick;
        logic [7:0]  rx;

        // sender idle percent per phase; the receiver cannot stall, so the
        // phases meant for receiver stalls run without gaps
        idle_plan = '{0, 79, 0, 7};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // read with nothing released, then DEL on an empty open line
        send_command(OP_READ, 8'h00);
        send_command(OP_RX, CH_DEL);
        // extreme bytes, a newline typed directly, one byte taken back
        send_command(OP_RX, 8'h00);
        send_command(OP_RX, 8'hFF);
        send_command(OP_RX, CH_LF);
        send_command(OP_RX, 8'h41);
        send_command(OP_RX, CH_DEL);
        // carriage return releases the line and stores a newline
        send_command(OP_RX, CH_CR);
        // read it all back (payload byte on a read is ignored), then empty
        repeat (5) send_command(OP_READ, 8'hFF);
        // carriage return on an empty line releases just the newline
        send_command(OP_RX, CH_CR);
        // echo characters typed as data, erased, then a DEL with nothing open
        send_command(OP_RX, CH_BS);
        send_command(OP_RX, CH_SP);
        send_command(OP_RX, CH_DEL);
        send_command(OP_RX, CH_DEL);
        send_command(OP_RX, CH_DEL);
        send_command(OP_READ, 8'h00);
        send_command(OP_READ, 8'h00);

        // ---------------- random part ----------------
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = idle_plan[phase];

            // typed lines: mostly bytes, with edits, line ends and reads
            repeat (25) begin
                pick = $urandom_range(99);
                rx   = 8'($urandom_range(255));
                if (pick < 25) begin
                    send_command(OP_READ, rx);
                end else if (pick < 35) begin
                    send_command(OP_RX, CH_DEL);
                end else if (pick < 45) begin
                    send_command(OP_RX, CH_CR);
                end else if (pick < 50) begin
                    send_command(OP_RX, CH_LF);
                end else begin
                    send_command(OP_RX, rx);
                end
            end

            // drain everything released, then one read too many
            while (board.readable() > 0) begin
                send_command(OP_READ, 8'($urandom_range(255)));
            end
            send_command(OP_READ, 8'($urandom_range(255)));
        end

        start <= 1'b0;

        // wait for every owed beat, then keep watching for anything stray
        while (board.owed_beats.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (board.errors == 0) begin
            $display("[line_edit_receive_buffer_unit] OK");
        end else begin
            $display("[line_edit_receive_buffer_unit] ERROR");
        end
        $finish;
    end

endmodule
